[design/c3f_pkg.sv]
package c3f_pkg;

  // frame geometry
  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned HEIGHT_LIMIT   = 4096;
  localparam int unsigned COL_W          = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W          = 11;
  localparam int unsigned HGT_W          = 13;
  localparam int unsigned ROW_W          = 13;

  // pixel and kernel formats
  localparam int unsigned KSIZE          = 3;
  localparam int unsigned TAPS           = KSIZE * KSIZE;
  localparam int unsigned NCH            = 3;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned PIX_W          = NCH * CH_W;
  localparam int unsigned LINE_W         = 2 * PIX_W;
  localparam int unsigned COEF_W         = 16;
  localparam int unsigned KROW_W         = KSIZE * COEF_W;
  localparam int unsigned COEF_FRAC_BITS = 8;
  localparam int unsigned PROD_W         = COEF_W + CH_W + 1;
  localparam int unsigned SUM_W          = PROD_W + 4;
  localparam int unsigned OUT_W          = 20;

  // configuration port
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 48;

  // reset values: 640x480, sharpen kernel
  localparam logic [WID_W-1:0]  WIDTH_RST  = WID_W'(640);
  localparam logic [HGT_W-1:0]  HEIGHT_RST = HGT_W'(480);
  localparam logic [KROW_W-1:0] KTOP_RST   = 48'h0000_FF00_0000;
  localparam logic [KROW_W-1:0] KMID_RST   = 48'hFF00_0500_FF00;
  localparam logic [KROW_W-1:0] KBOT_RST   = 48'h0000_FF00_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } cfg_reg_e;

  // one signed coefficient out of a packed kernel row
  function automatic logic signed [COEF_W-1:0] coef_at(
    input logic [KROW_W-1:0] row,
    input int unsigned       col
  );
    coef_at = $signed(row[COEF_W*col +: COEF_W]);
  endfunction

endpackage

[design/c3f_cfg_if.sv]
interface c3f_cfg_if;
  import c3f_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

[design/c3f_pix_if.sv]
interface c3f_pix_if;
  import c3f_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CH_W-1:0] blue_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] red_in;

  modport source (output valid, output opcode, output blue_in, output green_in,
                  output red_in, input ready);
  modport sink   (input valid, input opcode, input blue_in, input green_in,
                  input red_in, output ready);

endinterface

[design/c3f_res_if.sv]
interface c3f_res_if;
  import c3f_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] blue_out;
  logic signed [OUT_W-1:0] green_out;
  logic signed [OUT_W-1:0] red_out;
  logic                    frame_end;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output frame_end, input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  input frame_end, output ready);

endinterface

[design/conv3x3_zero_pad_filter.sv]
// 3x3 convolution over a raster stream of blue/green/red pixels, zero padding at the frame
// edges, one programmable Q8.8 kernel shared by all three channels (sharpen after reset).
// One beat is accepted per clock while the result side keeps up; a stall on the result side
// backs up through five register stages (line store read, window, products, sums, result
// register) before the input side stops. Each result is computed from the beat that
// completes its window, and that beat comes one row plus one pixel after the pixel the
// result belongs to: after the frame's last pixel send image_width+1 drain beats, the last
// of which yields the frame_end result. Whether a beat is a pixel or a drain follows from
// its position in the frame, not from opcode. The two line stores share one 1024 x 48
// memory, read once per beat and written once per pixel beat. Width and height writes
// restart the frame; all configuration writes must happen while the pipeline is empty.
module conv3x3_zero_pad_filter (
  input logic clk_i,
  input logic rst_ni,
  c3f_cfg_if.sink   cfg_i,
  c3f_pix_if.sink   pix_i,
  c3f_res_if.source res_o
);
  import c3f_pkg::*;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             col0;
    logic             top_v;
    logic             mid_v;
    logic             bot_v;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } s1_t;

  function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
    if (v == '0) begin
      clamp_width = WID_W'(1);
    end else if (v > WID_W'(MAX_WIDTH)) begin
      clamp_width = WID_W'(MAX_WIDTH);
    end else begin
      clamp_width = v;
    end
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
    if (v == '0) begin
      clamp_height = HGT_W'(1);
    end else if (v > HGT_W'(HEIGHT_LIMIT)) begin
      clamp_height = HGT_W'(HEIGHT_LIMIT);
    end else begin
      clamp_height = v;
    end
  endfunction

  // configuration
  logic [WID_W-1:0]  wid_q;
  logic [HGT_W-1:0]  hgt_q;
  logic [KROW_W-1:0] krow_q [KSIZE];
  cfg_reg_e          cfg_sel;
  logic              cfg_we;
  logic              geom_wr;

  // input position
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             col_wrap;
  logic             last_in;

  // pipeline handshake
  logic acc1, acc2, acc3, acc4, acc_out;
  logic in_fire, s1_move;
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;

  // stage 1: line store read data and window
  s1_t               s1_d, s1_q;
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] mem_rd_q;
  logic              byp_q;
  logic [LINE_W-1:0] byp_data_q;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic [PIX_W-1:0]  newcol [KSIZE];
  logic [PIX_W-1:0]  taps   [TAPS];
  logic [PIX_W-1:0]  win_d  [TAPS];
  logic [PIX_W-1:0]  win_q  [TAPS];

  // stages 2 to 4 and result register
  logic [PIX_W-1:0]         taps2_q [TAPS];
  logic                     last2_q, last3_q, last4_q;
  logic signed [PROD_W-1:0] prod_d  [NCH][TAPS];
  logic signed [PROD_W-1:0] prod_q  [NCH][TAPS];
  logic signed [SUM_W-1:0]  sum_d   [NCH];
  logic signed [SUM_W-1:0]  sum_q   [NCH];
  logic signed [OUT_W-1:0]  res_d   [NCH];
  logic signed [OUT_W-1:0]  res_q   [NCH];
  logic                     frame_end_q;

  // configuration decode
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_sel     = cfg_reg_e'(cfg_i.index);
  assign geom_wr     = cfg_we && (cfg_sel == REG_WIDTH || cfg_sel == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q     <= WIDTH_RST;
      hgt_q     <= HEIGHT_RST;
      krow_q[0] <= KTOP_RST;
      krow_q[1] <= KMID_RST;
      krow_q[2] <= KBOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_WIDTH:  wid_q     <= clamp_width(cfg_i.data[WID_W-1:0]);
        REG_HEIGHT: hgt_q     <= clamp_height(cfg_i.data[HGT_W-1:0]);
        REG_KTOP:   krow_q[0] <= cfg_i.data[KROW_W-1:0];
        REG_KMID:   krow_q[1] <= cfg_i.data[KROW_W-1:0];
        REG_KBOT:   krow_q[2] <= cfg_i.data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // ready chain: a stage takes a beat when empty or when it moves on
  assign acc_out     = !out_v_q || res_o.ready;
  assign acc4        = !v4_q || acc_out;
  assign acc3        = !v3_q || acc4;
  assign acc2        = !v2_q || acc3;
  assign s1_move     = v1_q && (!s1_q.emit || acc2);
  assign acc1        = !v1_q || s1_move;
  assign pix_i.ready = acc1;
  assign in_fire     = pix_i.valid && acc1;

  // position of the incoming beat and what it contributes
  assign col_wrap = (WID_W'(col_q) + WID_W'(1)) >= wid_q;
  assign last_in  = (row_q == ROW_W'(hgt_q) + ROW_W'(1)) && (col_q == '0);

  always_comb begin
    s1_d       = '0;
    s1_d.emit  = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
    s1_d.last  = last_in;
    s1_d.col0  = (col_q == '0);
    s1_d.top_v = (row_q >= ROW_W'(2)) && ((row_q - ROW_W'(2)) < ROW_W'(hgt_q));
    s1_d.mid_v = (row_q >= ROW_W'(1)) && ((row_q - ROW_W'(1)) < ROW_W'(hgt_q));
    s1_d.bot_v = row_q < ROW_W'(hgt_q);
    s1_d.col   = col_q;
    s1_d.pix   = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (geom_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (last_in) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_wrap) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (acc1) begin
      v1_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // line stores: upper half is two rows back, lower half one row back
  assign line_rd = byp_q ? byp_data_q : mem_rd_q;
  assign line_wr = {line_rd[PIX_W-1:0], s1_q.pix};

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_q.bot_v) begin
      line_mem[s1_q.col] <= line_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_rd_q <= line_mem[col_q];
    end
  end

  // same-address write and read in one cycle (single-column frames)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_fire) begin
      byp_q <= s1_move && s1_q.bot_v && (s1_q.col == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byp_data_q <= line_wr;
    end
  end

  // new window column, zero outside the frame
  assign newcol[0] = s1_q.top_v ? line_rd[LINE_W-1:PIX_W] : '0;
  assign newcol[1] = s1_q.mid_v ? line_rd[PIX_W-1:0] : '0;
  assign newcol[2] = s1_q.bot_v ? s1_q.pix : '0;

  // window shift; at a row start the right neighbor lies outside the frame
  always_comb begin
    for (int k = 0; k < KSIZE; k++) begin
      taps[k*KSIZE]     = win_q[k*KSIZE+1];
      taps[k*KSIZE+1]   = win_q[k*KSIZE+2];
      taps[k*KSIZE+2]   = s1_q.col0 ? '0 : newcol[k];
      if (s1_q.last) begin
        win_d[k*KSIZE]   = '0;
        win_d[k*KSIZE+1] = '0;
        win_d[k*KSIZE+2] = '0;
      end else if (s1_q.col0) begin
        win_d[k*KSIZE]   = '0;
        win_d[k*KSIZE+1] = '0;
        win_d[k*KSIZE+2] = newcol[k];
      end else begin
        win_d[k*KSIZE]   = taps[k*KSIZE];
        win_d[k*KSIZE+1] = taps[k*KSIZE+1];
        win_d[k*KSIZE+2] = newcol[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TAPS; t++) begin
        win_q[t] <= '0;
      end
    end else if (geom_wr) begin
      for (int t = 0; t < TAPS; t++) begin
        win_q[t] <= '0;
      end
    end else if (s1_move) begin
      win_q <= win_d;
    end
  end

  // stage 2: window snapshot of an emitting beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (acc2) begin
      v2_q <= v1_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc2 && v1_q && s1_q.emit) begin
      taps2_q <= taps;
      last2_q <= s1_q.last;
    end
  end

  // stage 3: one product per tap and channel
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      for (int t = 0; t < TAPS; t++) begin
        prod_d[ch][t] = coef_at(krow_q[t / KSIZE], t % KSIZE) *
                        $signed({1'b0, taps2_q[t][CH_W*ch +: CH_W]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (acc3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc3 && v2_q) begin
      prod_q  <= prod_d;
      last3_q <= last2_q;
    end
  end

  // stage 4: sum of the nine products
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      sum_d[ch] = '0;
      for (int t = 0; t < TAPS; t++) begin
        sum_d[ch] = sum_d[ch] + SUM_W'(prod_q[ch][t]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (acc4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc4 && v3_q) begin
      sum_q   <= sum_d;
      last4_q <= last3_q;
    end
  end

  // drop the fraction, rounding toward zero; the result always fits 20 bits
  always_comb begin
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] quot;
    for (int ch = 0; ch < NCH; ch++) begin
      biased     = sum_q[ch] + (sum_q[ch][SUM_W-1] ?
                   SUM_W'((1 << COEF_FRAC_BITS) - 1) : SUM_W'(0));
      quot       = biased >>> COEF_FRAC_BITS;
      res_d[ch]  = quot[OUT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (acc_out) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_out && v4_q) begin
      res_q       <= res_d;
      frame_end_q <= last4_q;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.blue_out  = res_q[0];
  assign res_o.green_out = res_q[1];
  assign res_o.red_out   = res_q[2];
  assign res_o.frame_end = frame_end_q;

  // input side only stops when the result side is stalled
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled without a stalled result");

  // column counter stays inside the row
  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    WID_W'(col_q) < wid_q)
    else $error("input column beyond image width");

  // the frame's last beat leaves an empty window behind
  a_window_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_q.last) |=> (win_q[0] == '0 && win_q[4] == '0 && win_q[8] == '0))
    else $error("window not cleared at frame end");

endmodule
